// ----- src/mm2_pkg.sv -----
package mm2_pkg;

  // Mixing constant and shift amounts
  localparam logic [31:0] MIX_M     = 32'h5bd1e995;
  localparam int unsigned MIX_R     = 24;
  localparam int unsigned FIN_R1    = 13;
  localparam int unsigned FIN_R2    = 15;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // How a request folds into the accumulator
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_WORD = 2'd1,
    KIND_TAIL = 2'd2
  } kind_t;

  // One classified request as it crosses the queue
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        first;
    logic        last;
    logic [30:0] length;
  } entry_t;

  // Keep the low bytes of a partial word
  function automatic logic [31:0] tail_mask(input logic [2:0] n);
    logic [31:0] m;
    begin
      case (n)
        3'd1:    m = 32'h0000_00ff;
        3'd2:    m = 32'h0000_ffff;
        3'd3:    m = 32'h00ff_ffff;
        default: m = 32'h0000_0000;
      endcase
      return m;
    end
  endfunction

endpackage

// ----- src/mm2_front.sv -----
module mm2_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [31:0]         data_word,
  input  logic [2:0]          byte_count,
  input  logic                first_word,
  input  logic                last_word,
  input  logic [30:0]         message_length,
  output logic                q_push,
  input  logic                q_full,
  output mm2_pkg::entry_t     q_entry
);

  logic                s1_valid;
  mm2_pkg::kind_t      s1_kind;
  logic [31:0]         s1_val;
  logic                s1_first;
  logic                s1_last;
  logic [30:0]         s1_len;

  logic                s2_valid;
  mm2_pkg::entry_t     s2_entry;

  logic                adv;
  logic                accept;
  mm2_pkg::kind_t      in_kind;
  logic [31:0]         in_val;
  logic [31:0]         s1_mix;

  // Advance the whole front unless the queue refuses the oldest request
  assign adv    = !s2_valid || !q_full;
  assign full   = !adv;
  assign accept = push && adv;
  assign q_push = s2_valid && !q_full;
  assign q_entry = s2_entry;

  // Classify the request and start the word mix
  always_comb begin
    if (byte_count inside {[3'd4:3'd7]}) begin
      in_kind = mm2_pkg::KIND_WORD;
      in_val  = data_word * mm2_pkg::MIX_M;
    end else if (byte_count inside {[3'd1:3'd3]}) begin
      in_kind = mm2_pkg::KIND_TAIL;
      in_val  = data_word & mm2_pkg::tail_mask(byte_count);
    end else begin
      in_kind = mm2_pkg::KIND_NONE;
      in_val  = 32'h0;
    end
  end

  // Finish the word mix: k ^= k >> 24, k *= m
  always_comb begin
    if (s1_kind == mm2_pkg::KIND_WORD) begin
      s1_mix = (s1_val ^ (s1_val >> mm2_pkg::MIX_R)) * mm2_pkg::MIX_M;
    end else begin
      s1_mix = s1_val;
    end
  end

  // Valid bits of the two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  // Payload of the two stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind         <= in_kind;
      s1_val          <= in_val;
      s1_first        <= first_word;
      s1_last         <= last_word;
      s1_len          <= message_length;
      s2_entry.kind   <= s1_kind;
      s2_entry.value  <= s1_mix;
      s2_entry.first  <= s1_first;
      s2_entry.last   <= s1_last;
      s2_entry.length <= s1_len;
    end
  end

endmodule

// ----- src/mm2_queue.sv -----
module mm2_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  mm2_pkg::entry_t  wr_entry,
  output logic             q_full,
  input  logic             rd,
  output mm2_pkg::entry_t  rd_entry,
  output logic             q_empty
);

  mm2_pkg::entry_t                  mem [mm2_pkg::QUEUE_DEPTH];
  logic [mm2_pkg::QUEUE_AW-1:0]     wr_ptr;
  logic [mm2_pkg::QUEUE_AW-1:0]     rd_ptr;
  logic [mm2_pkg::QUEUE_AW:0]       count;

  assign q_full   = (count == (mm2_pkg::QUEUE_AW+1)'(mm2_pkg::QUEUE_DEPTH));
  assign q_empty  = (count == '0);
  assign rd_entry = mem[rd_ptr];

  // Store an incoming request
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/mm2_back.sv -----
module mm2_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [31:0]      cfg_data,
  input  mm2_pkg::entry_t  q_entry,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [31:0]      hash_value
);

  logic [31:0] hash_seed;
  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [31:0] start;

  logic        a_valid;
  logic [31:0] a_acc;
  logic        b_valid;
  logic [31:0] b_prod;
  logic        out_valid;
  logic [31:0] out_hash;
  logic        adv;

  // Stall the back only when a finished hash is still waiting
  assign adv        = !out_valid || pop;
  assign q_pop      = adv && !q_empty;
  assign empty      = !out_valid;
  assign hash_value = out_hash;

  // Fold one request into the accumulator
  always_comb begin
    start = q_entry.first ? (hash_seed ^ {1'b0, q_entry.length}) : acc;
    case (q_entry.kind)
      mm2_pkg::KIND_WORD: acc_next = (start * mm2_pkg::MIX_M) ^ q_entry.value;
      mm2_pkg::KIND_TAIL: acc_next = (start ^ q_entry.value) * mm2_pkg::MIX_M;
      default:            acc_next = start;
    endcase
  end

  // Hold the seed and the running hash
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= 32'h0;
      acc       <= 32'h0;
    end else begin
      if (cfg_write) begin
        hash_seed <= cfg_data;
      end
      if (q_pop) begin
        acc <= acc_next;
      end
    end
  end

  // Finalize valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= q_pop && q_entry.last;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  // Finalize: h ^= h >> 13, h *= m, h ^= h >> 15
  always_ff @(posedge clk) begin
    if (adv) begin
      a_acc    <= acc_next;
      b_prod   <= (a_acc ^ (a_acc >> mm2_pkg::FIN_R1)) * mm2_pkg::MIX_M;
      out_hash <= b_prod ^ (b_prod >> mm2_pkg::FIN_R2);
    end
  end

endmodule

// ----- src/murmur2_hash32.sv -----
// MurmurHash2, 32-bit, over a message sent as little-endian 32-bit words.
// Input channel: drive push with data_word, byte_count, first_word,
// last_word and message_length; a request is taken when push is high and
// full is low. first_word loads the accumulator with seed XOR length;
// last_word finalizes and emits one hash.
// Result channel: hash_value is valid while empty is low and leaves on a
// cycle with pop high.
// Seed: write cfg_data with cfg_write high while the block is idle.
// Throughput: one request per cycle while full stays low, set by the single
// multiply and XOR of the accumulator recurrence in the back end.
// Path of the last request after the edge that takes it: the second front
// mix stage, the queue write, the fold and two finalize stages; then empty goes low.
// Reset clears the seed and accumulator to zero and empties every stage.
// A stalled receiver holds the result; the back end stops, the four-entry
// queue fills, and then full rises until pop frees space.
module murmur2_hash32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        first_word,
  input  logic        last_word,
  input  logic [30:0] message_length,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] hash_value,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  mm2_pkg::entry_t q_in;
  mm2_pkg::entry_t q_out;

  // Accept and classify requests, mix full words
  mm2_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_word      (data_word),
    .byte_count     (byte_count),
    .first_word     (first_word),
    .last_word      (last_word),
    .message_length (message_length),
    .q_push         (q_push),
    .q_full         (q_full),
    .q_entry        (q_in)
  );

  // Decouple front and back
  mm2_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_entry (q_in),
    .q_full   (q_full),
    .rd       (q_pop),
    .rd_entry (q_out),
    .q_empty  (q_empty)
  );

  // Fold into the accumulator and finalize
  mm2_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .q_entry    (q_out),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .hash_value (hash_value)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !q_pop)
    else $error("queue read while empty");

  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    full |-> q_full)
    else $error("front stalled with room in the queue");

  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (empty && !q_empty) |-> q_pop)
    else $error("back idle while requests wait");
`endif

endmodule
